@@ rtl/murmur3_32_stream_hash_assert.svh @@
// Assertion macros for the streaming MurmurHash3 block.
// Depends on signals named clk and rst_n in the including module.
`ifndef MURMUR3_32_STREAM_HASH_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MUR3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mur3 assertion failed");

// Next-cycle implication, disabled during reset.
`define MUR3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mur3 assertion failed");

`endif

@@ rtl/mur3_pkg.sv @@
// Shared types, constants and helper functions for the MurmurHash3 block.
// No dependencies; used by mur3_mul and murmur3_32_stream_hash.
`default_nettype none

package mur3_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_MIX,
        ST_F0,
        ST_F1,
        ST_F2
    } state_t;

    typedef enum logic [1:0] {
        MUL_C1,
        MUL_C2,
        MUL_M1,
        MUL_M2
    } mul_sel_t;

    typedef struct packed {
        logic        en;
        mul_sel_t    sel;
        logic [31:0] operand;
    } mul_req_t;

    function automatic logic [31:0] mul_const(input mul_sel_t sel);
        logic [31:0] c;
        unique case (sel)
            MUL_C1:  c = MIX_C1;
            MUL_C2:  c = MIX_C2;
            MUL_M1:  c = FIN_M1;
            MUL_M2:  c = FIN_M2;
            default: c = MIX_C1;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

    // Keep only the valid low bytes of a tail word.
    function automatic logic [31:0] byte_mask(input logic [2:0] count);
        logic [31:0] m;
        unique case (count)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mur3_mul.sv @@
// Shared constant multiplier: operand times a selected constant, low 32 bits.
// Depends on mur3_pkg for the request struct and constant table.
`default_nettype none

module mur3_mul (
    input  wire logic              clk,
    input  wire mur3_pkg::mul_req_t req,
    output logic [31:0]            prod
);

    logic [31:0] low_prod;
    logic [31:0] prod_reg;
    logic [31:0] prod_next;

    // Keep only the low half of the product; the hash works modulo 2^32.
    assign low_prod = req.operand * mur3_pkg::mul_const(req.sel);
    // Hold the product unless a new multiply is issued.
    assign prod_next = req.en ? low_prod : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/murmur3_32_stream_hash.sv @@
// Streaming MurmurHash3 x86_32 top level: sequencer, hash state, output beat.
// Depends on mur3_pkg, mur3_mul and murmur3_32_stream_hash_assert.svh.
//
// Usage:
//   Input channel (data_valid/data_ready) carries one 32-bit little-endian
//   word per beat with byte_count, last and seed. The seed is taken on the
//   first beat of a message; byte_count below four counts only on the last
//   beat, and values above four count as four.
//   Output channel (hash_valid/hash_ready) carries one hash_value beat per
//   message, after its last word.
//   Sequence: every multiply goes through one shared registered multiplier.
//   A full or tail word passes the accept, two multiplies and mix steps;
//   the finalizer adds two multiplies and an output step, and an empty
//   last word goes straight from accept to the finalizer. data_ready is
//   high only in the idle step.
//   Stall: the output register holds a finished hash while the receiver
//   stalls; the next message's words keep flowing, and only a second
//   finished hash waits in the output step until the register frees.
//   Reset: clears the sequencer, the message flag and the output valid.
`default_nettype none

module murmur3_32_stream_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        data_valid,
    output logic             data_ready,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last,
    input  wire logic [31:0] seed,
    output logic             hash_valid,
    input  wire logic        hash_ready,
    output logic [31:0]      hash_value
);

    `include "murmur3_32_stream_hash_assert.svh"

    mur3_pkg::state_t   state_reg, state_next;
    mur3_pkg::mul_req_t mul_req;
    logic [31:0]        prod;

    logic [31:0] k_reg, k_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] len_reg, len_next;
    logic        in_msg_reg, in_msg_next;
    logic        last_reg, last_next;
    logic        full_reg, full_next;
    logic        hash_valid_reg, hash_valid_next;
    logic [31:0] hash_value_reg, hash_value_next;

    logic [2:0]  eff_count;
    logic [31:0] mix_h;
    logic [31:0] fin_t;

    mur3_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mur3_pkg::ST_IDLE;
            in_msg_reg     <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_msg_reg     <= in_msg_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        hash_reg       <= hash_next;
        len_reg        <= len_next;
        last_reg       <= last_next;
        full_reg       <= full_next;
        hash_value_reg <= hash_value_next;
    end

    // Short counts are honored only on the last word; above four means four.
    assign eff_count = (!last || byte_count > mur3_pkg::FULL_COUNT)
                       ? mur3_pkg::FULL_COUNT : byte_count;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        hash_next       = hash_reg;
        len_next        = len_reg;
        in_msg_next     = in_msg_reg;
        last_next       = last_reg;
        full_next       = full_reg;
        hash_value_next = hash_value_reg;
        // Drop the output beat once the receiver takes it.
        hash_valid_next = hash_valid_reg && !hash_ready;
        data_ready      = 1'b0;
        mul_req.en      = 1'b0;
        mul_req.sel     = mur3_pkg::MUL_C1;
        mul_req.operand = k_reg;
        mix_h           = hash_reg ^ prod;
        fin_t           = hash_reg ^ len_reg;

        unique case (state_reg)
            mur3_pkg::ST_IDLE:
            begin
                data_ready = 1'b1;
                if (data_valid)
                begin
                    // Load the seed on the first word of a message.
                    k_next      = data_word & mur3_pkg::byte_mask(eff_count);
                    hash_next   = in_msg_reg ? hash_reg : seed;
                    len_next    = (in_msg_reg ? len_reg : 32'd0) + 32'(eff_count);
                    in_msg_next = 1'b1;
                    last_next   = last;
                    full_next   = (eff_count == mur3_pkg::FULL_COUNT);
                    state_next  = (eff_count == 3'd0) ? mur3_pkg::ST_F0
                                                      : mur3_pkg::ST_K1;
                end
            end
            mur3_pkg::ST_K1:
            begin
                mul_req.en      = 1'b1;
                mul_req.sel     = mur3_pkg::MUL_C1;
                mul_req.operand = k_reg;
                state_next      = mur3_pkg::ST_K2;
            end
            mur3_pkg::ST_K2:
            begin
                mul_req.en      = 1'b1;
                mul_req.sel     = mur3_pkg::MUL_C2;
                mul_req.operand = mur3_pkg::rotl15(prod);
                state_next      = mur3_pkg::ST_MIX;
            end
            mur3_pkg::ST_MIX:
            begin
                // Full words rotate and add; a tail word only xors in.
                if (full_reg)
                begin
                    mix_h = mur3_pkg::rotl13(hash_reg ^ prod);
                    mix_h = (mix_h << 2) + mix_h + mur3_pkg::MIX_ADD;
                end
                hash_next  = mix_h;
                state_next = last_reg ? mur3_pkg::ST_F0 : mur3_pkg::ST_IDLE;
            end
            mur3_pkg::ST_F0:
            begin
                fin_t           = fin_t ^ (fin_t >> 16);
                mul_req.en      = 1'b1;
                mul_req.sel     = mur3_pkg::MUL_M1;
                mul_req.operand = fin_t;
                in_msg_next     = 1'b0;
                state_next      = mur3_pkg::ST_F1;
            end
            mur3_pkg::ST_F1:
            begin
                mul_req.en      = 1'b1;
                mul_req.sel     = mur3_pkg::MUL_M2;
                mul_req.operand = prod ^ (prod >> 13);
                state_next      = mur3_pkg::ST_F2;
            end
            mur3_pkg::ST_F2:
            begin
                // Hold here while the previous hash still waits.
                if (!hash_valid_reg || hash_ready)
                begin
                    hash_value_next = prod ^ (prod >> 16);
                    hash_valid_next = 1'b1;
                    state_next      = mur3_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mur3_pkg::ST_IDLE;
            end
        endcase
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

    `MUR3_ASSERT_IMP(a_rose_after_fin, $rose(hash_valid_reg),
                     $past(state_reg) == mur3_pkg::ST_F2)
    `MUR3_ASSERT_IMP(a_mix_after_k2, state_reg == mur3_pkg::ST_MIX,
                     $past(state_reg) == mur3_pkg::ST_K2)
    `MUR3_ASSERT_NXT(a_word_starts_mul, data_valid && data_ready && !last,
                     state_reg == mur3_pkg::ST_K1)
    `MUR3_ASSERT_NXT(a_hold_on_stall,
                     state_reg == mur3_pkg::ST_F2 && hash_valid_reg && !hash_ready,
                     state_reg == mur3_pkg::ST_F2 && $stable(prod))

endmodule

`default_nettype wire
